FILE: hdl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants of the fenced ring allocator: opcodes, result
// codes, register indexes, controller states and datapath step codes.
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int unsigned MAX_EPOCH_SLOTS  = 8;
  localparam int unsigned SLOT_W           = $clog2(MAX_EPOCH_SLOTS);
  localparam int unsigned MAX_ALIGN_LOG2   = 6;
  localparam int unsigned CFG_INDEX_W      = 1;
  localparam logic [31:0] CAPACITY_RESET   = 32'd65536;
  localparam logic [1:0]  SLOTS_LOG2_RESET = 2'd3;

  typedef enum logic [1:0] {
    OP_CLAIM  = 2'd0,
    OP_EPOCH  = 2'd1,
    OP_RETIRE = 2'd2,
    OP_NONE   = 2'd3
  } fra_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_FENCE     = 3'd2,
    ST_UNRETIRED = 3'd3,
    ST_ALIGN     = 3'd4
  } fra_status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAPACITY   = 1'd0,
    REG_SLOTS_LOG2 = 1'd1
  } fra_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_FIT,
    S_SUM,
    S_HEAD,
    S_CHECK,
    S_EPOCH,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } fra_state_e;

  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_ACCEPT,
    STEP_ALIGN,
    STEP_FIT,
    STEP_SUM,
    STEP_HEAD,
    STEP_CHECK,
    STEP_EPOCH,
    STEP_SCAN,
    STEP_UPDATE,
    STEP_RESP
  } fra_step_e;

  typedef struct packed {
    fra_step_e step;
  } fra_cmd_t;

  typedef struct packed {
    logic claim_err;
    logic scan_last;
    logic out_free;
  } fra_sts_t;

endpackage

FILE: hdl/fra_ctrl.sv
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer of the fenced ring allocator. Walks one item through the claim,
// epoch or retire steps of the datapath and hands its result to the output.
// ----------------------------------------------------------------------------
module fra_ctrl import fra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  op_i,
  output logic        in_ready_o,
  input  fra_sts_t    sts_i,
  output fra_cmd_t    cmd_o
);

  fra_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (fra_op_e'(op_i))
            OP_CLAIM:  state_d = S_ALIGN;
            OP_EPOCH:  state_d = S_EPOCH;
            OP_RETIRE: state_d = S_SCAN;
            OP_NONE:   state_d = S_RESP;
          endcase
        end
      end
      S_ALIGN:  state_d = sts_i.claim_err ? S_RESP : S_FIT;
      S_FIT:    state_d = S_SUM;
      S_SUM:    state_d = S_HEAD;
      S_HEAD:   state_d = S_CHECK;
      S_CHECK:  state_d = S_RESP;
      S_EPOCH:  state_d = S_RESP;
      S_SCAN:   state_d = sts_i.scan_last ? S_UPDATE : S_SCAN;
      S_UPDATE: state_d = S_RESP;
      S_RESP:   state_d = sts_i.out_free ? S_IDLE : S_RESP;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.step = STEP_NONE;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i ? STEP_ACCEPT : STEP_NONE;
      end
      S_ALIGN:  cmd_o.step = STEP_ALIGN;
      S_FIT:    cmd_o.step = STEP_FIT;
      S_SUM:    cmd_o.step = STEP_SUM;
      S_HEAD:   cmd_o.step = STEP_HEAD;
      S_CHECK:  cmd_o.step = STEP_CHECK;
      S_EPOCH:  cmd_o.step = STEP_EPOCH;
      S_SCAN:   cmd_o.step = STEP_SCAN;
      S_UPDATE: cmd_o.step = STEP_UPDATE;
      S_RESP:   cmd_o.step = sts_i.out_free ? STEP_RESP : STEP_NONE;
      default:  cmd_o.step = STEP_NONE;
    endcase
  end

endmodule

FILE: hdl/fra_dp.sv
// ----------------------------------------------------------------------------
// fra_dp
// Datapath of the fenced ring allocator: ring counters, fence mark slots,
// configuration registers, claim arithmetic and the output register.
// ----------------------------------------------------------------------------
module fra_dp import fra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fra_cmd_t               cmd_i,
  output fra_sts_t               sts_o,
  input  logic [31:0]            size_i,
  input  logic [2:0]             align_log2_i,
  input  logic [63:0]            fence_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [31:0]            offset_o,
  output logic [31:0]            in_use_o
);

  // configuration
  logic [31:0] cap_q;
  logic [1:0]  slots_log2_q;

  // allocator state
  logic [63:0] head_q, tail_q, latest_q;
  logic [31:0] roff_q;
  logic [MAX_EPOCH_SLOTS-1:0] mark_vld_q;
  logic [63:0] mark_fence_q [MAX_EPOCH_SLOTS];
  logic [63:0] mark_end_q   [MAX_EPOCH_SLOTS];

  // per-item working registers
  logic [31:0]  size_q;
  logic [2:0]   align_q;
  logic [63:0]  fence_q;
  fra_status_e  status_q;
  logic [31:0]  off_q;
  logic [32:0]  aligned_q;
  logic [33:0]  sum_q, cs_q, delta_q;
  logic         fits_q;
  logic [31:0]  new_off_q, payload_q, offset_q;
  logic [63:0]  claim_head_q, target_q;
  logic [SLOT_W-1:0] idx_q;

  // output register
  logic        out_valid_q;
  fra_status_e out_status_q;
  logic [31:0] out_offset_q, out_in_use_q;

  logic [SLOT_W-1:0] slot_mask;
  always_comb begin
    unique case (slots_log2_q)
      2'd0:    slot_mask = SLOT_W'(0);
      2'd1:    slot_mask = SLOT_W'(1);
      2'd2:    slot_mask = SLOT_W'(3);
      default: slot_mask = SLOT_W'(7);
    endcase
  end

  // align step
  logic [31:0] off_sel;
  logic [6:0]  amask;
  logic [32:0] aligned;
  logic        size_bad, align_bad;
  assign off_sel   = (roff_q < cap_q) ? roff_q : 32'd0;
  assign amask     = 7'((8'd1 << align_q) - 8'd1);
  assign aligned   = ({1'b0, off_sel} + {26'd0, amask}) & ~{26'd0, amask};
  assign size_bad  = (size_q == 32'd0) || (size_q > cap_q);
  assign align_bad = (align_q > 3'(MAX_ALIGN_LOG2));

  // fit and sum steps
  logic [33:0] sum_d;
  logic [31:0] new_off_pre;
  assign sum_d       = {1'b0, aligned_q} + {2'd0, size_q};
  assign new_off_pre = fits_q ? sum_q[31:0] : size_q;

  // check step
  logic [63:0] used;
  assign used = claim_head_q - tail_q;

  // mark slot read port: one address per cycle
  logic [SLOT_W-1:0] ep_slot, rd_idx;
  logic [63:0]       rd_fence, rd_end;
  logic              rd_vld;
  assign ep_slot  = latest_q[SLOT_W-1:0] & slot_mask;
  assign rd_idx   = (cmd_i.step == STEP_EPOCH) ? ep_slot : idx_q;
  assign rd_vld   = mark_vld_q[rd_idx];
  assign rd_fence = mark_fence_q[rd_idx];
  assign rd_end   = mark_end_q[rd_idx];

  logic ep_stale, ep_busy;
  assign ep_stale = (fence_q <= latest_q);
  assign ep_busy  = rd_vld && (tail_q < rd_end);

  assign sts_o.claim_err = size_bad || align_bad;
  assign sts_o.scan_last = (idx_q == slot_mask);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAPACITY_RESET;
      slots_log2_q <= SLOTS_LOG2_RESET;
      head_q       <= '0;
      tail_q       <= '0;
      latest_q     <= '0;
      roff_q       <= '0;
      mark_vld_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CAPACITY) begin
          cap_q <= cfg_data_i;
        end else begin
          slots_log2_q <= cfg_data_i[1:0];
        end
      end
      if (cmd_i.step == STEP_RESP) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.step)
        STEP_CHECK: begin
          if (used <= {32'd0, cap_q}) begin
            head_q <= claim_head_q;
            roff_q <= new_off_q;
          end
        end
        STEP_EPOCH: begin
          if (!ep_stale && !ep_busy) begin
            mark_vld_q[ep_slot] <= 1'b1;
            latest_q            <= fence_q;
          end
        end
        STEP_UPDATE: begin
          if (tail_q < target_q) begin
            tail_q <= target_q;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and mark payload
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      STEP_ACCEPT: begin
        size_q   <= size_i;
        align_q  <= align_log2_i;
        fence_q  <= fence_i;
        status_q <= ST_OK;
        offset_q <= '0;
        target_q <= '0;
        idx_q    <= '0;
      end
      STEP_ALIGN: begin
        off_q     <= off_sel;
        aligned_q <= aligned;
        if (size_bad) begin
          status_q <= ST_NO_SPACE;
        end else if (align_bad) begin
          status_q <= ST_ALIGN;
        end
      end
      STEP_FIT: begin
        sum_q  <= sum_d;
        fits_q <= (sum_d <= {2'd0, cap_q});
        cs_q   <= {2'd0, cap_q} + {2'd0, size_q};
      end
      STEP_SUM: begin
        delta_q   <= (fits_q ? sum_q : cs_q) - {2'd0, off_q};
        new_off_q <= (new_off_pre == cap_q) ? 32'd0 : new_off_pre;
        payload_q <= fits_q ? aligned_q[31:0] : 32'd0;
      end
      STEP_HEAD: claim_head_q <= head_q + {30'd0, delta_q};
      STEP_CHECK: begin
        if (used > {32'd0, cap_q}) begin
          status_q <= ST_NO_SPACE;
        end else begin
          offset_q <= payload_q;
        end
      end
      STEP_EPOCH: begin
        if (ep_stale) begin
          status_q <= ST_FENCE;
        end else if (ep_busy) begin
          status_q <= ST_UNRETIRED;
        end else begin
          mark_end_q[ep_slot]   <= head_q;
          mark_fence_q[ep_slot] <= latest_q;
        end
      end
      STEP_SCAN: begin
        if (rd_vld && (rd_fence <= fence_q) && (rd_end > target_q)) begin
          target_q <= rd_end;
        end
        idx_q <= idx_q + SLOT_W'(1);
      end
      STEP_RESP: begin
        out_status_q <= status_q;
        out_offset_q <= offset_q;
        out_in_use_q <= head_q[31:0] - tail_q[31:0];
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign offset_o    = out_offset_q;
  assign in_use_o    = out_in_use_q;

endmodule

FILE: hdl/fenced_ring_allocator.sv
// ----------------------------------------------------------------------------
// fenced_ring_allocator
// Ring buffer allocator whose space is reclaimed by epoch fences.
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken while the previous result
// still waits in the output register. A claim steps through align, fit, sum,
// the 64-bit head add and the 64-bit space check, and ends at align when it
// is refused for its size or alignment; a begin epoch has only its epoch step,
// and a retire reads the mark slots in use (1 to 8) one per cycle through a
// single read port before its update step. An unused opcode goes straight to
// the response. A result waits for the output register to drain before the
// block is ready again.
// Configuration writes take effect on the next cycle.
module fenced_ring_allocator import fra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             op_i,
  input  logic [31:0]            size_i,
  input  logic [2:0]             align_log2_i,
  input  logic [63:0]            fence_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic [31:0]            offset_o,
  output logic [31:0]            in_use_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  fra_cmd_t cmd;
  fra_sts_t sts;

  fra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fra_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .size_i       (size_i),
    .align_log2_i (align_log2_i),
    .fence_i      (fence_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .offset_o     (offset_o),
    .in_use_o     (in_use_o)
  );

endmodule

FILE: hdl/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Port-level checks of the fenced ring allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fra_port_checks import fra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_o,
  input  logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  logic [2:0]             status_o,
  input  logic [31:0]            offset_o,
  input  logic [31:0]            in_use_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(offset_o) && $stable(in_use_o))
    else $error("stalled result changed");

  // one item at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_NO_SPACE
      || status_o == ST_FENCE || status_o == ST_UNRETIRED || status_o == ST_ALIGN)
    else $error("result code out of range");

  // a failed item never reports an offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> offset_o == 32'd0)
    else $error("offset reported on a failed item");

endmodule

bind fenced_ring_allocator fra_port_checks u_fra_port_checks (.*);

FILE: verif/fra_checker.sv
// ----------------------------------------------------------------------------
// fra_checker
// Watches the command and response channels of the fenced ring allocator,
// predicts each response from its own copy of the ring, fence marks and
// registers, and compares the responses field by field in order.
// ----------------------------------------------------------------------------
module fra_checker import fra_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             op_i,
  input  logic [31:0]            size_i,
  input  logic [2:0]             align_log2_i,
  input  logic [63:0]            fence_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [2:0]             status_i,
  input  logic [31:0]            offset_i,
  input  logic [31:0]            in_use_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output int                     fail_count_o,
  output int                     due_count_o
);

  typedef struct packed {
    fra_status_e status;
    logic [31:0] offset;
    logic [31:0] in_use;
  } alloc_resp_t;

  logic [31:0] capacity;
  logic [1:0]  slots_log2;
  logic [63:0] head_count;
  logic [63:0] tail_count;
  logic [31:0] ring_off;
  logic [63:0] latest_fence;
  logic [63:0] mark_fence [MAX_EPOCH_SLOTS];
  logic [63:0] mark_end [MAX_EPOCH_SLOTS];
  alloc_resp_t due_resps [$];
  int          fails;

  // Apply one command to the shadow ring and return the response it gives.
  function automatic alloc_resp_t apply_ring_op(input fra_op_e op,
                                                input logic [31:0] size,
                                                input logic [2:0] align_log2,
                                                input logic [63:0] fence);
    alloc_resp_t r;
    logic [63:0] align;
    logic [63:0] off;
    logic [63:0] aligned;
    logic [63:0] payload;
    logic [63:0] claim_head;
    logic [63:0] new_off;
    logic [63:0] target;
    logic [63:0] used;
    logic [2:0]  smask;
    logic [2:0]  slot;
    r.status = ST_OK;
    r.offset = '0;
    smask = 3'((8'd1 << slots_log2) - 8'd1);
    case (op)
      OP_CLAIM: begin
        if (size == 0 || size > capacity) begin
          r.status = ST_NO_SPACE;
        end else if (align_log2 > MAX_ALIGN_LOG2) begin
          r.status = ST_ALIGN;
        end else begin
          align = 64'd1 << align_log2;
          // a lowered capacity can leave the offset past the end: restart at 0
          off = (ring_off < capacity) ? 64'(ring_off) : 64'd0;
          aligned = (off + align - 64'd1) & ~(align - 64'd1);
          if (aligned + size <= capacity) begin
            payload    = aligned;
            claim_head = head_count + (aligned - off) + size;
            new_off    = aligned + size;
          end else begin
            // wrap: the tail gap is wasted
            payload    = '0;
            claim_head = head_count + (capacity - off) + size;
            new_off    = 64'(size);
          end
          if (new_off >= capacity) new_off = '0;
          if (claim_head - tail_count > capacity) begin
            r.status = ST_NO_SPACE;
          end else begin
            head_count = claim_head;
            ring_off   = new_off[31:0];
            r.offset   = payload[31:0];
          end
        end
      end
      OP_EPOCH: begin
        slot = latest_fence[2:0] & smask;
        if (fence <= latest_fence) begin
          r.status = ST_FENCE;
        end else if (mark_fence[slot] != '1 && tail_count < mark_end[slot]) begin
          r.status = ST_UNRETIRED;
        end else begin
          mark_end[slot]   = head_count;
          mark_fence[slot] = latest_fence;
          latest_fence     = fence;
        end
      end
      OP_RETIRE: begin
        target = '0;
        for (int i = 0; i <= int'(smask); i++) begin
          if (mark_fence[i] != '1 && mark_fence[i] <= fence && mark_end[i] > target)
            target = mark_end[i];
        end
        if (tail_count < target) tail_count = target;
      end
      default: ;
    endcase
    used = head_count - tail_count;
    r.in_use = used[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_resp_t want;
    if (!rst_ni) begin
      capacity     = CAPACITY_RESET;
      slots_log2   = SLOTS_LOG2_RESET;
      head_count   = '0;
      tail_count   = '0;
      ring_off     = '0;
      latest_fence = '0;
      for (int i = 0; i < MAX_EPOCH_SLOTS; i++) begin
        mark_fence[i] = '1;
        mark_end[i]   = '0;
      end
      due_resps.delete();
      fails = 0;
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (fra_reg_e'(cfg_index_i))
          REG_CAPACITY:   capacity = cfg_data_i;
          REG_SLOTS_LOG2: slots_log2 = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (due_resps.size() == 0) begin
          $error("response transfer with nothing expected: status %0d offset %0d in_use %0d",
                 status_i, offset_i, in_use_i);
          fails++;
        end else begin
          want = due_resps.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fails++;
          end
          if (offset_i !== want.offset) begin
            $error("offset: expected %0d, actual %0d", want.offset, offset_i);
            fails++;
          end
          if (in_use_i !== want.in_use) begin
            $error("in_use: expected %0d, actual %0d", want.in_use, in_use_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        due_resps.push_back(apply_ring_op(fra_op_e'(op_i), size_i, align_log2_i, fence_i));
      fail_count_o <= fails;
      due_count_o  <= due_resps.size();
    end
  end

endmodule

FILE: verif/tb_fenced_ring_allocator.sv
// ----------------------------------------------------------------------------
// tb_fenced_ring_allocator
// Drives the fenced ring allocator with directed corner cases and then
// claim / begin epoch / retire sequences under several ring sizes and slot
// counts, with random idle bursts on both channels; the checker judges.
// ----------------------------------------------------------------------------
module tb_fenced_ring_allocator;
  import fra_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 150;
  localparam logic [63:0] TOP_FENCE = 64'hFFFF_FFFF_FFFF_FFFE;

  logic                   clk_i        = 1'b0;
  logic                   rst_ni       = 1'b0;
  logic                   in_valid_i   = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             op_i         = OP_CLAIM;
  logic [31:0]            size_i       = '0;
  logic [2:0]             align_log2_i = '0;
  logic [63:0]            fence_i      = '0;
  logic                   out_valid_o;
  logic                   out_ready_i  = 1'b0;
  logic [2:0]             status_o;
  logic [31:0]            offset_o;
  logic [31:0]            in_use_o;
  logic                   cfg_we_i     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i  = REG_CAPACITY;
  logic [31:0]            cfg_data_i   = '0;

  int          fail_count;
  int          due_count;
  int          idle_cycles = 0;
  bit          gaps_on     = 1'b0;
  bit          stalls_on   = 1'b0;
  bit          hold_off    = 1'b0;
  logic [63:0] fence_seq   = '0;
  logic [31:0] cur_cap     = CAPACITY_RESET;

  logic [31:0] cap_seq  [6] = '{32'd256, 32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd64, 32'd65536};
  logic [1:0]  slot_seq [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3};

  fenced_ring_allocator dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .op_i, .size_i, .align_log2_i, .fence_i,
    .out_valid_o, .out_ready_i, .status_o, .offset_o, .in_use_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  fra_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i (in_ready_o), .op_i, .size_i, .align_log2_i, .fence_i,
    .out_valid_i (out_valid_o), .out_ready_i, .status_i (status_o),
    .offset_i (offset_o), .in_use_i (in_use_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o (fail_count), .due_count_o (due_count)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Response side: random stall bursts, one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  task automatic send_op(input fra_op_e op, input logic [31:0] size,
                         input logic [2:0] al, input logic [63:0] fence);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    size_i       <= size;
    align_log2_i <= al;
    fence_i      <= fence;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every response has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
  endtask

  task automatic set_config(input logic [31:0] cap, input logic [1:0] slots_log2);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_CAPACITY;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    cfg_index_i <= REG_SLOTS_LOG2;
    cfg_data_i  <= {30'($urandom), slots_log2};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_cap = cap;
  endtask

  function automatic logic [31:0] claim_size();
    logic [31:0] lim;
    lim = cur_cap >> 3;
    if (lim == 0) lim = 1;
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return cur_cap;
      2:       return cur_cap + 32'd1;
      3:       return $urandom;
      default: return $urandom_range(1, lim);
    endcase
  endfunction

  // Mostly orderly claim / epoch / retire traffic, some noise.
  task automatic run_phase(input int count);
    int          done;
    int unsigned pick;
    fra_op_e     op;
    logic [63:0] f;
    logic [31:0] lag;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 19);
      lag  = $urandom_range(0, 3);
      f    = {$urandom, $urandom};
      if (pick < 10) begin
        op = OP_CLAIM;
        send_op(op, claim_size(), 3'($urandom_range(0, 6)), f);
      end else if (pick < 14) begin
        op = OP_EPOCH;
        fence_seq = fence_seq + $urandom_range(1, 4);
        send_op(op, $urandom, 3'($urandom), fence_seq);
      end else if (pick < 18) begin
        op = OP_RETIRE;
        send_op(op, $urandom, 3'($urandom), (fence_seq > lag) ? fence_seq - lag : '0);
      end else begin
        op = fra_op_e'($urandom_range(0, 3));
        // stale fences only: a fresh large one would stall all later epochs
        if (op == OP_EPOCH) f = fence_seq - 64'($urandom_range(0, 20));
        send_op(op, $urandom, 3'($urandom), f);
      end
      if (op != OP_NONE) done++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    send_op(OP_CLAIM,  32'd0,          3'd0, '0);
    send_op(OP_CLAIM,  32'd65537,      3'd7, '0);
    send_op(OP_CLAIM,  32'd1,          3'd7, '0);
    send_op(OP_CLAIM,  32'd100,        3'd0, '0);
    send_op(OP_CLAIM,  32'd3,          3'd6, '0);
    send_op(OP_CLAIM,  32'hFFFF_FFFF,  3'd3, '0);
    send_op(OP_NONE,   32'hFFFF_FFFF,  3'd7, 64'h5A5A_A5A5_0F0F_F0F0);
    send_op(OP_EPOCH,  32'd0,          3'd0, 64'd0);
    send_op(OP_EPOCH,  32'd0,          3'd0, 64'd5);
    send_op(OP_EPOCH,  32'd0,          3'd0, 64'd5);
    send_op(OP_CLAIM,  32'd40000,      3'd5, '0);
    send_op(OP_CLAIM,  32'd30000,      3'd0, '0);
    send_op(OP_EPOCH,  32'd0,          3'd0, 64'd9);
    send_op(OP_RETIRE, 32'd0,          3'd0, 64'd5);
    send_op(OP_CLAIM,  32'd30000,      3'd2, '0);
    send_op(OP_RETIRE, 32'd0,          3'd0, 64'd0);
    send_op(OP_CLAIM,  32'd65536,      3'd0, '0);
    send_op(OP_RETIRE, 32'd0,          3'd0, TOP_FENCE);
    send_op(OP_EPOCH,  32'd0,          3'd0, 64'd12);
    send_op(OP_RETIRE, 32'd0,          3'd0, 64'd9);
    fence_seq = 64'd12;

    // long response hold-off so the allocator backs up its command input
    hold_off = 1'b1;
    run_phase(PHASE_ITEMS);

    for (int p = 0; p < 6; p++) begin
      drain();
      set_config(cap_seq[p], slot_seq[p]);
      gaps_on   = (p == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      stalls_on = (p == 5) ? 1'b0 : 1'($urandom_range(0, 1));
      run_phase(PHASE_ITEMS);
    end

    // saturate the fence: the second epoch must be refused
    send_op(OP_RETIRE, $urandom, 3'($urandom), TOP_FENCE);
    send_op(OP_EPOCH,  $urandom, 3'($urandom), TOP_FENCE);
    send_op(OP_EPOCH,  $urandom, 3'($urandom), TOP_FENCE);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: fenced_ring_allocator.f
hdl/fra_pkg.sv
hdl/fra_ctrl.sv
hdl/fra_dp.sv
hdl/fenced_ring_allocator.sv
hdl/fra_checker.sv
verif/fra_checker.sv
verif/tb_fenced_ring_allocator.sv
